/* hdl/rau_pkg.sv */
// Shared constants and types for the rational arithmetic unit.
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  // Command codes
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_CMP = 3'd3,
    CMD_RED = 3'd4
  } cmd_t;

  // Compare outcome codes
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Request to the shared divider
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  // Reply from the shared divider
  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

endpackage

/* hdl/rau_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module rau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);

  logic                         busy_r, busy_nxt;
  logic [rau_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  rau_pkg::word_t               q_r, q_nxt;
  rau_pkg::word_t               rem_r, rem_nxt;
  rau_pkg::word_t               d_r, d_nxt;
  logic                         done_r, done_nxt;
  logic [rau_pkg::WORD_BITS:0]  trial;

  // One shift-subtract step a cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[rau_pkg::WORD_BITS-1]} - {1'b0, d_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rau_pkg::CNT_BITS'(rau_pkg::WORD_BITS);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      if (!trial[rau_pkg::WORD_BITS]) begin
        rem_nxt = trial[rau_pkg::WORD_BITS-1:0];
        q_nxt   = {q_r[rau_pkg::WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[rau_pkg::WORD_BITS-2:0], q_r[rau_pkg::WORD_BITS-1]};
        q_nxt   = {q_r[rau_pkg::WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == rau_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r)) else $error("divider busy and done together");
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0 || $past(req.start) || !$past(busy_r))
    else $error("divider count stale");
`endif

endmodule

/* hdl/rational_arithmetic_unit.sv */
// Rational arithmetic unit: sequencer, shared multiplier and divider.
// Path to out_valid: add/sub and mul/compare run the multiplier states; unknown or zero-numerator reduce go to ST_OUT.
// Reduce: Euclid steps on the shared divider, then two divisions by the gcd and output;
//   with a zero denominator the Euclid loop is skipped.
// Throughput: one item at a time; in_ready only when the sequencer is idle and no result waits.
// Reset: rst_n synchronous active low clears the sequencer and output valid.
module rational_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic signed [31:0] in_num_a,
  input  logic [31:0] in_den_a,
  input  logic signed [31:0] in_num_b,
  input  logic [31:0] in_den_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_res_num,
  output logic [31:0] out_res_den,
  output logic [1:0]  out_order,
  output logic        out_bad_denominator
);

  localparam int W = rau_pkg::WORD_BITS;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL1 = 8'b0000_0010,
    ST_MUL2 = 8'b0000_0100,
    ST_MUL3 = 8'b0000_1000,
    ST_GCD  = 8'b0001_0000,
    ST_DIVN = 8'b0010_0000,
    ST_DIVD = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [2:0]             cmd_r;
  logic signed [W:0]      na_r, nb_r;
  logic [W:0]             da_r, db_r;
  logic                   bad_r;
  logic signed [2*W+1:0]  prod_r, p0_r;
  logic signed [W:0]      mx, my;
  logic                   pend_r;
  rau_pkg::word_t         gx_r, gy_r, g_r, mag_r, qn_r;
  logic                   neg_r;
  rau_pkg::div_req_t      dreq;
  rau_pkg::div_rsp_t      drsp;
  logic                   ov_r;
  rau_pkg::word_t         rn_r, rd_r;
  logic [1:0]             ord_r;
  logic                   obad_r;
  logic                   acc;
  logic [2*W+1:0]         sumv;
  logic signed [2*W+1:0]  diffv;

  assign acc      = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE) && !ov_r;

  // Shared signed multiplier operand select; product lands in prod_r a state later
  always_comb begin
    case (st_r)
      ST_MUL2: begin mx = nb_r; my = da_r; end
      ST_MUL3: begin mx = da_r; my = db_r; end
      default: begin mx = na_r; my = (cmd_r == rau_pkg::CMD_MUL) ? nb_r : db_r; end
    endcase
  end

  always_comb begin
    sumv  = (cmd_r == rau_pkg::CMD_SUB) ? p0_r - prod_r : p0_r + prod_r;
    diffv = p0_r - prod_r;
  end

  // Divider requests from the sequencer
  always_comb begin
    dreq = '0;
    if (st_r == ST_GCD && pend_r) begin
      dreq.start = 1'b1; dreq.dividend = gx_r; dreq.divisor = gy_r;
    end else if (st_r == ST_DIVN && pend_r) begin
      dreq.start = 1'b1; dreq.dividend = mag_r; dreq.divisor = g_r;
    end else if (st_r == ST_DIVD && pend_r) begin
      dreq.start = 1'b1; dreq.dividend = da_r[W-1:0]; dreq.divisor = g_r;
    end
  end

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (acc) begin
        if (in_cmd == rau_pkg::CMD_RED) st_nxt = (in_num_a == '0) ? ST_OUT : ST_GCD;
        else if (in_cmd > rau_pkg::CMD_RED) st_nxt = ST_OUT;
        else st_nxt = ST_MUL1;
      end
      ST_MUL1: st_nxt = (cmd_r == rau_pkg::CMD_MUL) ? ST_MUL3 : ST_MUL2;
      ST_MUL2: st_nxt = (cmd_r == rau_pkg::CMD_CMP) ? ST_OUT : ST_MUL3;
      ST_MUL3: st_nxt = ST_OUT;
      ST_GCD:  if (!pend_r && drsp.done && drsp.rem == '0) st_nxt = ST_DIVN;
               else if (!pend_r && gy_r == '0) st_nxt = ST_DIVN;
      ST_DIVN: if (!pend_r && drsp.done) st_nxt = ST_DIVD;
      ST_DIVD: if (!pend_r && drsp.done) st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (st_r == ST_OUT) ov_r <= 1'b1;
      if (acc) pend_r <= (in_cmd == rau_pkg::CMD_RED) && (in_den_a != '0);
      else if (dreq.start) pend_r <= 1'b0;
      else if (drsp.done && st_r == ST_GCD && drsp.rem != '0) pend_r <= 1'b1;
      else if (st_r == ST_GCD && st_nxt == ST_DIVN) pend_r <= 1'b1;
      else if (drsp.done && st_r == ST_DIVN) pend_r <= 1'b1;
    end
    prod_r <= (2*W+2)'(mx * my);
    if (acc) begin
      cmd_r <= in_cmd;
      na_r  <= {in_num_a[W-1], in_num_a[W-1:0]};
      nb_r  <= {in_num_b[W-1], in_num_b[W-1:0]};
      da_r  <= {1'b0, in_den_a[W-1:0]};
      db_r  <= {1'b0, in_den_b[W-1:0]};
      neg_r <= in_num_a[W-1];
      mag_r <= in_num_a[W-1] ? W'(-in_num_a[W-1:0]) : in_num_a[W-1:0];
      gx_r  <= in_num_a[W-1] ? W'(-in_num_a[W-1:0]) : in_num_a[W-1:0];
      gy_r  <= in_den_a[W-1:0];
      case (in_cmd)
        rau_pkg::CMD_RED: bad_r <= (in_den_a[W-1:0] == '0);
        rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL, rau_pkg::CMD_CMP:
          bad_r <= (in_den_a[W-1:0] == '0) || (in_den_b[W-1:0] == '0);
        default: bad_r <= 1'b0;
      endcase
    end
    if (st_r == ST_MUL2) p0_r <= prod_r;
    if (st_r == ST_MUL3) rn_r <= (cmd_r == rau_pkg::CMD_MUL) ? prod_r[W-1:0] : sumv[W-1:0];
    // Euclid step on remainder
    if (st_r == ST_GCD && !pend_r && drsp.done) begin
      gx_r <= gy_r;
      gy_r <= drsp.rem;
    end
    if (st_r == ST_GCD && st_nxt == ST_DIVN)
      g_r <= (gy_r == '0) ? gx_r : gy_r;
    if (st_r == ST_DIVN && !pend_r && drsp.done) qn_r <= drsp.quot;
    if (st_r == ST_DIVD && !pend_r && drsp.done) begin
      rn_r <= neg_r ? W'(-qn_r) : qn_r;
      rd_r <= drsp.quot;
    end
    if (st_r == ST_OUT) begin
      obad_r <= bad_r;
      if (cmd_r == rau_pkg::CMD_CMP) begin
        ord_r <= bad_r ? rau_pkg::ORD_EQUAL :
                 diffv[2*W+1] ? rau_pkg::ORD_LESS :
                 (diffv == '0) ? rau_pkg::ORD_EQUAL : rau_pkg::ORD_GREATER;
      end else begin
        ord_r <= rau_pkg::ORD_LESS;
      end
      if (cmd_r inside {rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL}) begin
        rd_r <= prod_r[W-1:0];
      end else if (cmd_r == rau_pkg::CMD_CMP || cmd_r > rau_pkg::CMD_RED) begin
        rn_r <= '0; rd_r <= '0;
      end else if (cmd_r == rau_pkg::CMD_RED && na_r == '0) begin
        rn_r <= '0; rd_r <= W'(1);
      end
    end
  end

  // Compare needs the second product in prod_r at ST_OUT, first in p0_r
  assign out_valid           = ov_r;
  assign out_res_num         = 32'($signed(rn_r));
  assign out_res_den         = 32'(rd_r);
  assign out_order           = ord_r;
  assign out_bad_denominator = obad_r;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ready) else $error("ready while busy");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r == ST_OUT)) else $error("result without finish");
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
`endif

endmodule
